>>> rtl/core/mcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcd_pkg;

	// result queue depth; at least two so one byte's pair of results always fits
	localparam int unsigned OUT_DEPTH = 4;

	// byte sent back ahead of an unrecognised opcode
	localparam logic [7:0] ERR_BYTE = 8'hFA;

	// opcodes with a fixed meaning (0x00..0x7F are the shift family)
	localparam logic [7:0] OP_SET_LOW    = 8'h80;
	localparam logic [7:0] OP_READ_LOW   = 8'h81;
	localparam logic [7:0] OP_SET_HIGH   = 8'h82;
	localparam logic [7:0] OP_READ_HIGH  = 8'h83;
	localparam logic [7:0] OP_LOOP_ON    = 8'h84;
	localparam logic [7:0] OP_LOOP_OFF   = 8'h85;
	localparam logic [7:0] OP_SET_DIV    = 8'h86;
	localparam logic [7:0] OP_FLUSH      = 8'h87;
	localparam logic [7:0] OP_WAIT_IO_HI = 8'h88;
	localparam logic [7:0] OP_WAIT_IO_LO = 8'h89;
	localparam logic [7:0] OP_DIV5_OFF   = 8'h8A;
	localparam logic [7:0] OP_DIV5_ON    = 8'h8B;
	localparam logic [7:0] OP_3PH_ON     = 8'h8C;
	localparam logic [7:0] OP_3PH_OFF    = 8'h8D;
	localparam logic [7:0] OP_CLK_BITS   = 8'h8E;
	localparam logic [7:0] OP_CLK_BYTES  = 8'h8F;
	localparam logic [7:0] OP_CLK_IO_HI  = 8'h94;
	localparam logic [7:0] OP_CLK_IO_LO  = 8'h95;
	localparam logic [7:0] OP_ADAPT_ON   = 8'h96;
	localparam logic [7:0] OP_ADAPT_OFF  = 8'h97;
	localparam logic [7:0] OP_CLKB_IO_HI = 8'h9C;
	localparam logic [7:0] OP_CLKB_IO_LO = 8'h9D;

	typedef enum logic [3:0] {
		PH_CMD       = 4'd0,
		PH_LEN_LO    = 4'd1,
		PH_LEN_HI    = 4'd2,
		PH_WBYTES    = 4'd3,
		PH_BITLEN    = 4'd4,
		PH_WBITS     = 4'd5,
		PH_TMSLEN    = 4'd6,
		PH_TMSDATA   = 4'd7,
		PH_GPIO_VAL  = 4'd8,
		PH_GPIO_DIR  = 4'd9,
		PH_DIV_LO    = 4'd10,
		PH_DIV_HI    = 4'd11,
		PH_CLKN_LO   = 4'd12,
		PH_CLKN_HI   = 4'd13,
		PH_CLKN_BITS = 4'd14
	} phase_t;

	typedef enum logic [3:0] {
		ACT_RESPOND = 4'd0,
		ACT_TDI     = 4'd1,
		ACT_TMS     = 4'd2,
		ACT_CLOCK   = 4'd3,
		ACT_GPIO_LO = 4'd4,
		ACT_GPIO_HI = 4'd5,
		ACT_DIVISOR = 4'd6,
		ACT_SAMPLE  = 4'd7,
		ACT_FLUSH   = 4'd8
	} action_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  data;
		logic [7:0]  aux;
		logic [3:0]  bit_count;
		logic [19:0] repeat_count;
		logic        capture;
		logic        lsb_first;
		logic        loopback_on;
		logic [15:0] divisor_value;
		logic        divide_by_five;
		logic        last;
	} result_t;

	// what the parser hands to the result queue for one byte
	typedef struct packed {
		logic [1:0] count;
		result_t    res0;
		result_t    res1;
	} dec_out_t;

endpackage

`default_nettype wire

>>> rtl/core/mcd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module mcd_parser (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                fire,
	input  wire  [7:0]         host_byte,
	output mcd_pkg::dec_out_t  dec
);

	// parser and engine state
	mcd_pkg::phase_t phase_q, phase_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [16:0] rem_q, rem_d;
	logic [3:0]  nbits_q, nbits_d;
	logic [15:0] div_q, div_d;
	logic        div5_q, div5_d;
	logic        loop_q, loop_d;
	logic [7:0]  lo_val_q, lo_val_d;
	logic [7:0]  lo_dir_q, lo_dir_d;
	logic [7:0]  hi_val_q, hi_val_d;
	logic [7:0]  hi_dir_q, hi_dir_d;

	mcd_pkg::result_t r0, r1;
	logic [1:0]  n_res;
	logic [16:0] len_sum;
	logic [16:0] clk_len;
	logic [3:0]  new_bits;

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7 - i] = v[i];
		end
		return r;
	endfunction

	// out-of-range bit counts fall back to a full byte
	function automatic logic [3:0] cur_bits(input logic [3:0] n);
		return (n == 4'd0 || n > 4'd8) ? 4'd8 : n;
	endfunction

	function automatic logic [7:0] few_bits(input logic [7:0] b, input logic [3:0] n,
		input logic lsb);
		logic [7:0] r;
		r = rev8(b) >> (4'd8 - n);
		return lsb ? b : r;
	endfunction

	function automatic mcd_pkg::result_t respond(input logic [7:0] b);
		mcd_pkg::result_t r;
		r        = '0;
		r.action = mcd_pkg::ACT_RESPOND;
		r.data   = b;
		return r;
	endfunction

	function automatic mcd_pkg::result_t tdi(input logic [7:0] d, input logic [3:0] n,
		input logic [19:0] rep, input logic [7:0] cmd, input logic loop);
		mcd_pkg::result_t r;
		r              = '0;
		r.action       = mcd_pkg::ACT_TDI;
		r.data         = d;
		r.bit_count    = n;
		r.repeat_count = rep;
		r.capture      = cmd[5];
		r.lsb_first    = cmd[3];
		r.loopback_on  = loop;
		return r;
	endfunction

	function automatic mcd_pkg::result_t plain(input mcd_pkg::action_t a);
		mcd_pkg::result_t r;
		r        = '0;
		r.action = a;
		return r;
	endfunction

	function automatic mcd_pkg::result_t divisor(input logic [15:0] d, input logic d5);
		mcd_pkg::result_t r;
		r                = '0;
		r.action         = mcd_pkg::ACT_DIVISOR;
		r.divisor_value  = d;
		r.divide_by_five = d5;
		return r;
	endfunction

	// decode of one byte: next state and up to two results
	always_comb begin
		phase_d  = phase_q;
		cmd_d    = cmd_q;
		rem_d    = rem_q;
		nbits_d  = nbits_q;
		div_d    = div_q;
		div5_d   = div5_q;
		loop_d   = loop_q;
		lo_val_d = lo_val_q;
		lo_dir_d = lo_dir_q;
		hi_val_d = hi_val_q;
		hi_dir_d = hi_dir_q;
		r0       = '0;
		r1       = '0;
		n_res    = 2'd0;
		len_sum  = {1'b0, host_byte, rem_q[7:0]} + 17'd1;
		clk_len  = {1'b0, host_byte, rem_q[7:0]};
		new_bits = {1'b0, host_byte[2:0]} + 4'd1;

		unique case (phase_q)
			mcd_pkg::PH_CMD: begin
				cmd_d = host_byte;
				if (!host_byte[7]) begin
					if (host_byte[6:4] == 3'b000) begin
						r0    = respond(mcd_pkg::ERR_BYTE);
						r1    = respond(host_byte);
						n_res = 2'd2;
					end else if (host_byte[6]) begin
						phase_d = mcd_pkg::PH_TMSLEN;
					end else if (host_byte[1]) begin
						phase_d = mcd_pkg::PH_BITLEN;
					end else begin
						phase_d = mcd_pkg::PH_LEN_LO;
					end
				end else begin
					unique case (host_byte) inside
						mcd_pkg::OP_SET_LOW, mcd_pkg::OP_SET_HIGH: begin
							phase_d = mcd_pkg::PH_GPIO_VAL;
						end
						mcd_pkg::OP_READ_LOW: begin
							r0    = plain(mcd_pkg::ACT_SAMPLE);
							n_res = 2'd1;
						end
						mcd_pkg::OP_READ_HIGH: begin
							r0    = respond(hi_val_q);
							n_res = 2'd1;
						end
						mcd_pkg::OP_LOOP_ON:  loop_d = 1'b1;
						mcd_pkg::OP_LOOP_OFF: loop_d = 1'b0;
						mcd_pkg::OP_SET_DIV:  phase_d = mcd_pkg::PH_DIV_LO;
						mcd_pkg::OP_FLUSH: begin
							r0    = plain(mcd_pkg::ACT_FLUSH);
							n_res = 2'd1;
						end
						mcd_pkg::OP_DIV5_OFF: begin
							div5_d = 1'b0;
							r0     = divisor(div_q, 1'b0);
							n_res  = 2'd1;
						end
						mcd_pkg::OP_DIV5_ON: begin
							div5_d = 1'b1;
							r0     = divisor(div_q, 1'b1);
							n_res  = 2'd1;
						end
						mcd_pkg::OP_CLK_BITS:  phase_d = mcd_pkg::PH_CLKN_BITS;
						mcd_pkg::OP_CLK_BYTES: phase_d = mcd_pkg::PH_CLKN_LO;
						mcd_pkg::OP_WAIT_IO_HI, mcd_pkg::OP_WAIT_IO_LO,
						mcd_pkg::OP_3PH_ON, mcd_pkg::OP_3PH_OFF,
						mcd_pkg::OP_CLK_IO_HI, mcd_pkg::OP_CLK_IO_LO,
						mcd_pkg::OP_ADAPT_ON, mcd_pkg::OP_ADAPT_OFF,
						mcd_pkg::OP_CLKB_IO_HI, mcd_pkg::OP_CLKB_IO_LO: begin
							// accepted, nothing to do
						end
						default: begin
							r0    = respond(mcd_pkg::ERR_BYTE);
							r1    = respond(host_byte);
							n_res = 2'd2;
						end
					endcase
				end
			end
			mcd_pkg::PH_LEN_LO: begin
				rem_d   = {9'd0, host_byte};
				phase_d = mcd_pkg::PH_LEN_HI;
			end
			mcd_pkg::PH_LEN_HI: begin
				rem_d = len_sum;
				if (cmd_q[4]) begin
					phase_d = cmd_q[1] ? mcd_pkg::PH_WBITS : mcd_pkg::PH_WBYTES;
				end else begin
					// read only: one shift action covers the whole run
					if (cmd_q[1]) begin
						r0 = tdi(8'h00, cur_bits(nbits_q), 20'd1, cmd_q, loop_q);
					end else begin
						r0 = tdi(8'h00, 4'd8, {3'd0, len_sum}, cmd_q, loop_q);
					end
					n_res   = 2'd1;
					rem_d   = '0;
					phase_d = mcd_pkg::PH_CMD;
				end
			end
			mcd_pkg::PH_WBYTES: begin
				r0      = tdi(cmd_q[3] ? host_byte : rev8(host_byte), 4'd8, 20'd1,
					cmd_q, loop_q);
				n_res   = 2'd1;
				rem_d   = rem_q - 17'd1;
				if (rem_d == '0) begin
					phase_d = mcd_pkg::PH_CMD;
				end
			end
			mcd_pkg::PH_BITLEN: begin
				nbits_d = new_bits;
				rem_d   = 17'd1;
				if (cmd_q[4]) begin
					phase_d = cmd_q[1] ? mcd_pkg::PH_WBITS : mcd_pkg::PH_WBYTES;
				end else begin
					if (cmd_q[1]) begin
						r0 = tdi(8'h00, new_bits, 20'd1, cmd_q, loop_q);
					end else begin
						r0 = tdi(8'h00, 4'd8, 20'd1, cmd_q, loop_q);
					end
					n_res   = 2'd1;
					rem_d   = '0;
					phase_d = mcd_pkg::PH_CMD;
				end
			end
			mcd_pkg::PH_WBITS: begin
				r0      = tdi(few_bits(host_byte, cur_bits(nbits_q), cmd_q[3]),
					cur_bits(nbits_q), 20'd1, cmd_q, loop_q);
				n_res   = 2'd1;
				phase_d = mcd_pkg::PH_CMD;
			end
			mcd_pkg::PH_TMSLEN: begin
				nbits_d = new_bits;
				phase_d = mcd_pkg::PH_TMSDATA;
			end
			mcd_pkg::PH_TMSDATA: begin
				r0              = plain(mcd_pkg::ACT_TMS);
				r0.data         = {1'b0, host_byte[6:0]};
				r0.aux          = {7'd0, host_byte[7]};
				r0.bit_count    = cur_bits(nbits_q);
				r0.repeat_count = 20'd1;
				r0.capture      = cmd_q[5];
				n_res           = 2'd1;
				phase_d         = mcd_pkg::PH_CMD;
			end
			mcd_pkg::PH_GPIO_VAL: begin
				if (cmd_q == mcd_pkg::OP_SET_LOW) begin
					lo_val_d = host_byte;
				end else begin
					hi_val_d = host_byte;
				end
				phase_d = mcd_pkg::PH_GPIO_DIR;
			end
			mcd_pkg::PH_GPIO_DIR: begin
				if (cmd_q == mcd_pkg::OP_SET_LOW) begin
					lo_dir_d = host_byte;
					r0       = plain(mcd_pkg::ACT_GPIO_LO);
					r0.data  = lo_val_q;
				end else begin
					hi_dir_d = host_byte;
					r0       = plain(mcd_pkg::ACT_GPIO_HI);
					r0.data  = hi_val_q;
				end
				r0.aux  = host_byte;
				n_res   = 2'd1;
				phase_d = mcd_pkg::PH_CMD;
			end
			mcd_pkg::PH_DIV_LO: begin
				div_d   = {8'd0, host_byte};
				phase_d = mcd_pkg::PH_DIV_HI;
			end
			mcd_pkg::PH_DIV_HI: begin
				div_d   = {host_byte, div_q[7:0]};
				r0      = divisor({host_byte, div_q[7:0]}, div5_q);
				n_res   = 2'd1;
				phase_d = mcd_pkg::PH_CMD;
			end
			mcd_pkg::PH_CLKN_BITS: begin
				r0              = plain(mcd_pkg::ACT_CLOCK);
				r0.repeat_count = {16'd0, new_bits};
				n_res           = 2'd1;
				phase_d         = mcd_pkg::PH_CMD;
			end
			mcd_pkg::PH_CLKN_LO: begin
				rem_d   = {9'd0, host_byte};
				phase_d = mcd_pkg::PH_CLKN_HI;
			end
			mcd_pkg::PH_CLKN_HI: begin
				rem_d           = clk_len;
				// repeat count covers (n + 1) whole bytes
				r0              = plain(mcd_pkg::ACT_CLOCK);
				r0.repeat_count = {clk_len + 17'd1, 3'd0};
				n_res           = 2'd1;
				phase_d         = mcd_pkg::PH_CMD;
			end
			default: begin
				phase_d = mcd_pkg::PH_CMD;
			end
		endcase

		// mark the final result of this byte
		if (n_res == 2'd1) begin
			r0.last = 1'b1;
		end else if (n_res == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	assign dec.count = n_res;
	assign dec.res0  = r0;
	assign dec.res1  = r1;

	// state update on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mcd_pkg::PH_CMD;
			cmd_q    <= '0;
			rem_q    <= '0;
			nbits_q  <= '0;
			div_q    <= '0;
			div5_q   <= 1'b1;
			loop_q   <= 1'b0;
			lo_val_q <= '0;
			lo_dir_q <= '0;
			hi_val_q <= '0;
			hi_dir_q <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			cmd_q    <= cmd_d;
			rem_q    <= rem_d;
			nbits_q  <= nbits_d;
			div_q    <= div_d;
			div5_q   <= div5_d;
			loop_q   <= loop_d;
			lo_val_q <= lo_val_d;
			lo_dir_q <= lo_dir_d;
			hi_val_q <= hi_val_d;
			hi_dir_q <= hi_dir_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/mcd_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module mcd_out_fifo #(
	parameter int unsigned Depth = mcd_pkg::OUT_DEPTH
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire  [1:0]         push_n,
	input  mcd_pkg::result_t   push0,
	input  mcd_pkg::result_t   push1,
	output logic               room,
	input  wire                pop,
	output mcd_pkg::result_t   head,
	output logic               valid
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	mcd_pkg::result_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PtrW-1:0] wr_ptr_p1, wr_ptr_p2;
	logic [CntW-1:0] cnt_q;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign wr_ptr_p1 = ptr_inc(wr_ptr_q);
	assign wr_ptr_p2 = ptr_inc(wr_ptr_p1);

	// room for a whole byte's worth of results
	assign room  = (cnt_q <= CntW'(Depth - 2));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_p1] <= push1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wr_ptr_q <= wr_ptr_p1;
			end else if (push_n == 2'd2) begin
				wr_ptr_q <= wr_ptr_p2;
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			cnt_q <= cnt_q + CntW'(push_n) - CntW'(pop);
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/mpsse_command_decoder_unit.sv
// Command stream decoder for a JTAG/GPIO engine.
// Host bytes enter on the s_ channel (s_tdata, one byte per beat); action
// items leave on the m_ channel, with the action code on m_tuser and
// m_tlast set on the final action caused by a given byte.
// Each accepted byte is decoded in the same cycle against the parser
// state and its zero, one or two actions are written into a small result
// queue; m_ offers the oldest queued action from the queue's registers.
// Throughput: one byte per cycle while each byte yields at most one action
// and m_tready stays high. Bytes that yield two actions (error replies)
// are written together, but the queue's single read port hands them out one at a time.
// s_tready is high while the queue has room for two actions, so a stalled
// receiver fills the queue and then holds off the host; queued actions
// wait unchanged until taken.
// Reset: parser waits for a command byte, queue empty, divide-by-five on,
// divisor, loopback and GPIO registers cleared.
`timescale 1ns / 1ps
`default_nettype none

module mpsse_command_decoder_unit #(
	parameter int unsigned OutDepth = mcd_pkg::OUT_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] host_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [63:0] m_tdata,   // [7:0] data, [15:8] aux, [19:16] bit_count,
	                               // [39:20] repeat_count, [40] capture,
	                               // [41] lsb_first, [42] loopback_on,
	                               // [58:43] divisor_value, [59] divide_by_five
	output logic [3:0]  m_tuser,   // [3:0] action
	output logic        m_tlast    // last
);

	mcd_pkg::dec_out_t dec;
	mcd_pkg::result_t  head;
	logic              fire;
	logic              room;
	logic [1:0]        push_n;

	assign fire     = s_tvalid & s_tready;
	assign s_tready = room;
	assign push_n   = fire ? dec.count : 2'd0;

	// byte parser
	mcd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.host_byte (s_tdata),
		.dec       (dec)
	);

	// result queue
	mcd_out_fifo #(
		.Depth (OutDepth)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.push0  (dec.res0),
		.push1  (dec.res1),
		.room   (room),
		.pop    (m_tvalid & m_tready),
		.head   (head),
		.valid  (m_tvalid)
	);

	// output beat packing
	assign m_tdata = {4'd0, head.divide_by_five, head.divisor_value, head.loopback_on,
		head.lsb_first, head.capture, head.repeat_count, head.bit_count, head.aux,
		head.data};
	assign m_tuser = head.action;
	assign m_tlast = head.last;

endmodule

`default_nettype wire

>>> bench/mpsse_command_decoder_unit_test.sv
`timescale 1ns / 1ps

module mpsse_command_decoder_unit_test;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned PRINT_CAP    = 100;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;

	mpsse_command_decoder_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	idle_mode_t  idle_mode = IDLE_NONE;
	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned checked_actions = 0;
	int unsigned active_bytes = 0;
	int unsigned noop_bytes = 0;

	// decoder state as the parser sees it
	mcd_pkg::phase_t parse_phase = mcd_pkg::PH_CMD;
	logic [7:0]  cmd_byte = 8'h00;
	logic [16:0] bytes_left = '0;
	logic [3:0]  held_bits = 4'd0;
	logic [15:0] div_val = 16'h0000;
	logic        div5 = 1'b1;
	logic        loop_en = 1'b0;
	logic [7:0]  lo_val = 8'h00;
	logic [7:0]  lo_dir = 8'h00;
	logic [7:0]  hi_val = 8'h00;
	logic [7:0]  hi_dir = 8'h00;

	mcd_pkg::result_t byte_actions[$];     // actions raised by the byte being decoded
	mcd_pkg::result_t pending_actions[$];  // actions still owed by the block, oldest first

	// ---------------------------------------------------------------- action predictor

	function automatic logic [7:0] bit_reverse(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++)
			r[7 - i] = v[i];
		return r;
	endfunction

	function automatic logic [3:0] bits_in_use();
		return (held_bits < 4'd1 || held_bits > 4'd8) ? 4'd8 : held_bits;
	endfunction

	function automatic mcd_pkg::result_t blank_action(input mcd_pkg::action_t a);
		mcd_pkg::result_t r;
		r = '0;
		r.action = a;
		return r;
	endfunction

	task automatic raise_action(input mcd_pkg::result_t r);
		if (byte_actions.size() < 2)
			byte_actions.push_back(r);
	endtask

	task automatic raise_reply(input logic [7:0] b);
		mcd_pkg::result_t r;
		r = blank_action(mcd_pkg::ACT_RESPOND);
		r.data = b;
		raise_action(r);
	endtask

	task automatic raise_divisor();
		mcd_pkg::result_t r;
		r = blank_action(mcd_pkg::ACT_DIVISOR);
		r.divisor_value = div_val;
		r.divide_by_five = div5;
		raise_action(r);
	endtask

	task automatic raise_tdi(input logic [7:0] d, input logic [3:0] n, input logic [19:0] rep);
		mcd_pkg::result_t r;
		r = blank_action(mcd_pkg::ACT_TDI);
		r.data = d;
		r.bit_count = n;
		r.repeat_count = rep;
		r.capture = cmd_byte[5];
		r.lsb_first = cmd_byte[3];
		r.loopback_on = loop_en;
		raise_action(r);
	endtask

	// part-byte shift: msb-first payload is reversed and right-aligned
	task automatic raise_bit_shift(input logic [7:0] b);
		logic [3:0]  n;
		int unsigned sh;
		n = bits_in_use();
		sh = 8 - n;
		raise_tdi(cmd_byte[3] ? b : (bit_reverse(b) >> sh), n, 20'd1);
	endtask

	// length complete: writes wait for payload, reads go out at once
	task automatic length_done();
		if (cmd_byte[4]) begin
			parse_phase = cmd_byte[1] ? mcd_pkg::PH_WBITS : mcd_pkg::PH_WBYTES;
		end else begin
			if (cmd_byte[1])
				raise_bit_shift(8'h00);
			else
				raise_tdi(8'h00, 4'd8, 20'(bytes_left));
			bytes_left = '0;
			parse_phase = mcd_pkg::PH_CMD;
		end
	endtask

	task automatic decode_opcode(input logic [7:0] b, output bit ignored);
		ignored = 1'b0;
		cmd_byte = b;
		if (b < 8'h80) begin
			if ((b & 8'h70) == 8'h00) begin
				raise_reply(mcd_pkg::ERR_BYTE);
				raise_reply(b);
			end else if (b[6]) begin
				parse_phase = mcd_pkg::PH_TMSLEN;
			end else if (b[1]) begin
				parse_phase = mcd_pkg::PH_BITLEN;
			end else begin
				parse_phase = mcd_pkg::PH_LEN_LO;
			end
		end else begin
			case (b)
				mcd_pkg::OP_SET_LOW, mcd_pkg::OP_SET_HIGH:
					parse_phase = mcd_pkg::PH_GPIO_VAL;
				mcd_pkg::OP_READ_LOW: raise_action(blank_action(mcd_pkg::ACT_SAMPLE));
				mcd_pkg::OP_READ_HIGH: raise_reply(hi_val);
				mcd_pkg::OP_LOOP_ON: loop_en = 1'b1;
				mcd_pkg::OP_LOOP_OFF: loop_en = 1'b0;
				mcd_pkg::OP_SET_DIV: parse_phase = mcd_pkg::PH_DIV_LO;
				mcd_pkg::OP_FLUSH: raise_action(blank_action(mcd_pkg::ACT_FLUSH));
				mcd_pkg::OP_DIV5_OFF: begin
					div5 = 1'b0;
					raise_divisor();
				end
				mcd_pkg::OP_DIV5_ON: begin
					div5 = 1'b1;
					raise_divisor();
				end
				mcd_pkg::OP_CLK_BITS: parse_phase = mcd_pkg::PH_CLKN_BITS;
				mcd_pkg::OP_CLK_BYTES: parse_phase = mcd_pkg::PH_CLKN_LO;
				mcd_pkg::OP_WAIT_IO_HI, mcd_pkg::OP_WAIT_IO_LO,
				mcd_pkg::OP_3PH_ON, mcd_pkg::OP_3PH_OFF,
				mcd_pkg::OP_CLK_IO_HI, mcd_pkg::OP_CLK_IO_LO,
				mcd_pkg::OP_ADAPT_ON, mcd_pkg::OP_ADAPT_OFF,
				mcd_pkg::OP_CLKB_IO_HI, mcd_pkg::OP_CLKB_IO_LO: ignored = 1'b1;
				default: begin
					raise_reply(mcd_pkg::ERR_BYTE);
					raise_reply(b);
				end
			endcase
		end
	endtask

	// one accepted host byte: advance the parser and queue what it owes
	task automatic predict_actions(input logic [7:0] b, output bit ignored);
		mcd_pkg::result_t r;
		ignored = 1'b0;
		byte_actions.delete();
		case (parse_phase)
			mcd_pkg::PH_CMD: decode_opcode(b, ignored);
			mcd_pkg::PH_LEN_LO: begin
				bytes_left = {9'd0, b};
				parse_phase = mcd_pkg::PH_LEN_HI;
			end
			mcd_pkg::PH_LEN_HI: begin
				bytes_left = {1'b0, b, bytes_left[7:0]} + 17'd1;
				length_done();
			end
			mcd_pkg::PH_WBYTES: begin
				raise_tdi(cmd_byte[3] ? b : bit_reverse(b), 4'd8, 20'd1);
				bytes_left = bytes_left - 17'd1;
				if (bytes_left == '0)
					parse_phase = mcd_pkg::PH_CMD;
			end
			mcd_pkg::PH_BITLEN: begin
				held_bits = {1'b0, b[2:0]} + 4'd1;
				bytes_left = 17'd1;
				length_done();
			end
			mcd_pkg::PH_WBITS: begin
				raise_bit_shift(b);
				parse_phase = mcd_pkg::PH_CMD;
			end
			mcd_pkg::PH_TMSLEN: begin
				held_bits = {1'b0, b[2:0]} + 4'd1;
				parse_phase = mcd_pkg::PH_TMSDATA;
			end
			mcd_pkg::PH_TMSDATA: begin
				r = blank_action(mcd_pkg::ACT_TMS);
				r.data = {1'b0, b[6:0]};
				r.aux = {7'd0, b[7]};
				r.bit_count = bits_in_use();
				r.repeat_count = 20'd1;
				r.capture = cmd_byte[5];
				raise_action(r);
				parse_phase = mcd_pkg::PH_CMD;
			end
			mcd_pkg::PH_GPIO_VAL: begin
				if (cmd_byte == mcd_pkg::OP_SET_LOW)
					lo_val = b;
				else
					hi_val = b;
				parse_phase = mcd_pkg::PH_GPIO_DIR;
			end
			mcd_pkg::PH_GPIO_DIR: begin
				if (cmd_byte == mcd_pkg::OP_SET_LOW) begin
					lo_dir = b;
					r = blank_action(mcd_pkg::ACT_GPIO_LO);
					r.data = lo_val;
					r.aux = lo_dir;
				end else begin
					hi_dir = b;
					r = blank_action(mcd_pkg::ACT_GPIO_HI);
					r.data = hi_val;
					r.aux = hi_dir;
				end
				raise_action(r);
				parse_phase = mcd_pkg::PH_CMD;
			end
			mcd_pkg::PH_DIV_LO: begin
				div_val = {8'h00, b};
				parse_phase = mcd_pkg::PH_DIV_HI;
			end
			mcd_pkg::PH_DIV_HI: begin
				div_val = {b, div_val[7:0]};
				raise_divisor();
				parse_phase = mcd_pkg::PH_CMD;
			end
			mcd_pkg::PH_CLKN_BITS: begin
				r = blank_action(mcd_pkg::ACT_CLOCK);
				r.repeat_count = 20'(b[2:0]) + 20'd1;
				raise_action(r);
				parse_phase = mcd_pkg::PH_CMD;
			end
			mcd_pkg::PH_CLKN_LO: begin
				bytes_left = {9'd0, b};
				parse_phase = mcd_pkg::PH_CLKN_HI;
			end
			mcd_pkg::PH_CLKN_HI: begin
				bytes_left = {1'b0, b, bytes_left[7:0]};
				r = blank_action(mcd_pkg::ACT_CLOCK);
				r.repeat_count = (20'(bytes_left[15:0]) + 20'd1) * 20'd8;
				raise_action(r);
				parse_phase = mcd_pkg::PH_CMD;
			end
			default: parse_phase = mcd_pkg::PH_CMD;
		endcase
		if (byte_actions.size() > 0) begin
			r = byte_actions.pop_back();
			r.last = 1'b1;
			byte_actions.push_back(r);
		end
		while (byte_actions.size() > 0)
			pending_actions.push_back(byte_actions.pop_front());
	endtask

	// ---------------------------------------------------------------- stimulus side

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(0, 99) < 62;
			IDLE_BOTH: return $urandom_range(0, 99) < 7;
			default: return 1'b0;
		endcase
	endfunction

	// offer one host byte, hold it until taken, then predict its actions
	task automatic send_host_byte(input logic [7:0] b);
		bit ignored;
		@(negedge clk);
		while (sender_idles()) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do
			@(posedge clk);
		while (!s_tready);
		predict_actions(b, ignored);
		if (ignored)
			noop_bytes++;
		else
			active_bytes++;
	endtask

	// random traffic: keep write-byte runs short, even when the stream is misaligned
	task automatic send_stream_byte(input logic [7:0] b);
		if (parse_phase == mcd_pkg::PH_LEN_HI && cmd_byte[4] && !cmd_byte[1])
			b = 8'h00;
		send_host_byte(b);
	endtask

	task automatic send_random_command();
		logic [7:0]  op;
		int unsigned len;
		if ($urandom_range(0, 99) < 10) begin
			// stray byte wherever the parser happens to be
			send_stream_byte(8'($urandom_range(0, 255)));
		end else if ($urandom_range(0, 99) < 50) begin
			op = 8'($urandom_range(0, 127));
			send_stream_byte(op);
			if ((op & 8'h70) == 8'h00) begin
				// unknown shift opcode, nothing follows
			end else if (op[6]) begin
				send_stream_byte(8'($urandom_range(0, 255)));
				send_stream_byte(8'($urandom_range(0, 255)));
			end else if (op[1]) begin
				send_stream_byte(8'($urandom_range(0, 255)));
				if (op[4])
					send_stream_byte(8'($urandom_range(0, 255)));
			end else if (op[4]) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
				send_stream_byte(8'(len));
				send_stream_byte(8'h00);
				repeat (len + 1)
					send_stream_byte(8'($urandom_range(0, 255)));
			end else begin
				send_stream_byte(8'($urandom_range(0, 255)));
				send_stream_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				                                             : 8'h00);
			end
		end else begin
			op = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(128, 255))
			                                 : 8'h80 + 8'($urandom_range(0, 31));
			send_stream_byte(op);
			case (op)
				mcd_pkg::OP_SET_LOW, mcd_pkg::OP_SET_HIGH,
				mcd_pkg::OP_SET_DIV, mcd_pkg::OP_CLK_BYTES: begin
					send_stream_byte(8'($urandom_range(0, 255)));
					send_stream_byte(8'($urandom_range(0, 255)));
				end
				mcd_pkg::OP_CLK_BITS: send_stream_byte(8'($urandom_range(0, 255)));
				default: ;
			endcase
		end
	endtask

	// drop valid and let every owed action come out
	task automatic drain_actions();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_actions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// receiver back-pressure
	always @(negedge clk) begin
		case (idle_mode)
			IDLE_RECEIVER: m_tready <= $urandom_range(0, 99) >= 62;
			IDLE_BOTH: m_tready <= $urandom_range(0, 99) >= 7;
			default: m_tready <= 1'b1;
		endcase
	end

	// ---------------------------------------------------------------- result checking

	task automatic report_mismatch(input string what, input int unsigned want,
	                               input int unsigned got);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t: action %0d %s: expected 0x%0h, got 0x%0h",
			         $realtime, checked_actions, what, want, got);
	endtask

	always @(posedge clk) begin
		mcd_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_actions.size() == 0) begin
				report_mismatch("unexpected beat, action code", 0, m_tuser);
			end else begin
				want = pending_actions.pop_front();
				if (m_tuser != want.action)
					report_mismatch("action", want.action, m_tuser);
				if (m_tdata[7:0] != want.data)
					report_mismatch("data", want.data, m_tdata[7:0]);
				if (m_tdata[15:8] != want.aux)
					report_mismatch("aux", want.aux, m_tdata[15:8]);
				if (m_tdata[19:16] != want.bit_count)
					report_mismatch("bit_count", want.bit_count, m_tdata[19:16]);
				if (m_tdata[39:20] != want.repeat_count)
					report_mismatch("repeat_count", want.repeat_count, m_tdata[39:20]);
				if (m_tdata[40] != want.capture)
					report_mismatch("capture", want.capture, m_tdata[40]);
				if (m_tdata[41] != want.lsb_first)
					report_mismatch("lsb_first", want.lsb_first, m_tdata[41]);
				if (m_tdata[42] != want.loopback_on)
					report_mismatch("loopback_on", want.loopback_on, m_tdata[42]);
				if (m_tdata[58:43] != want.divisor_value)
					report_mismatch("divisor_value", want.divisor_value, m_tdata[58:43]);
				if (m_tdata[59] != want.divide_by_five)
					report_mismatch("divide_by_five", want.divide_by_five, m_tdata[59]);
				if (m_tdata[63:60] != 4'd0)
					report_mismatch("tdata padding", 0, m_tdata[63:60]);
				if (m_tlast != want.last)
					report_mismatch("last", want.last, m_tlast);
			end
			checked_actions++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("stuck after %0d cycles with %0d actions owed",
			         cycle_count, pending_actions.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// fixed opcodes, GPIO, divisor and clock-only commands, error replies
	task automatic test_fixed_opcodes();
		idle_mode = IDLE_NONE;
		send_host_byte(8'h00);                 // shift opcode with no mode bits: error reply
		send_host_byte(8'hFF);                 // unknown high opcode
		send_host_byte(mcd_pkg::OP_READ_LOW);
		send_host_byte(mcd_pkg::OP_SET_HIGH);
		send_host_byte(8'hA5);
		send_host_byte(8'hFF);
		send_host_byte(mcd_pkg::OP_READ_HIGH); // returns the high value just set
		send_host_byte(mcd_pkg::OP_DIV5_OFF);
		send_host_byte(mcd_pkg::OP_SET_DIV);
		send_host_byte(8'hFF);
		send_host_byte(8'hFF);
		send_host_byte(mcd_pkg::OP_CLK_BITS);
		send_host_byte(8'hFF);
		send_host_byte(mcd_pkg::OP_CLK_BYTES); // longest clock run
		send_host_byte(8'hFF);
		send_host_byte(8'hFF);
		send_host_byte(mcd_pkg::OP_WAIT_IO_HI); // accepted, no action
		send_host_byte(mcd_pkg::OP_FLUSH);
		drain_actions();
	endtask

	// the shift family with loopback on, then off again
	task automatic test_shift_commands();
		idle_mode = IDLE_BOTH;
		send_host_byte(mcd_pkg::OP_LOOP_ON);
		send_host_byte(8'h19);                 // write one byte, lsb first
		send_host_byte(8'h00);
		send_host_byte(8'h00);
		send_host_byte(8'h81);
		send_host_byte(8'h20);                 // read-only byte run, longest length
		send_host_byte(8'hFF);
		send_host_byte(8'hFF);
		send_host_byte(8'h13);                 // msb-first write of three bits
		send_host_byte(8'h02);
		send_host_byte(8'hB4);
		send_host_byte(mcd_pkg::OP_LOOP_OFF);
		send_host_byte(8'h22);                 // read-only bit shift
		send_host_byte(8'h07);
		send_host_byte(8'h6B);                 // tms shift with capture, tdi high
		send_host_byte(8'h06);
		send_host_byte(8'h85);
		drain_actions();
	endtask

	task automatic test_random_stream(input idle_mode_t mode, input int unsigned target);
		int unsigned start;
		idle_mode = mode;
		start = active_bytes;
		while (active_bytes - start < target)
			send_random_command();
		drain_actions();
	endtask

	initial begin
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_fixed_opcodes();
		test_shift_commands();
		test_random_stream(IDLE_NONE, 300);
		test_random_stream(IDLE_SENDER, 300);
		test_random_stream(IDLE_RECEIVER, 300);
		test_random_stream(IDLE_BOTH, 300);

		if (pending_actions.size() != 0)
			report_mismatch("actions never delivered", 0, pending_actions.size());
		$display("Decoded %0d host bytes (%0d of them no-op opcodes) and checked %0d actions,",
		         active_bytes + noop_bytes, noop_bytes, checked_actions);
		$display("under steady flow, sender gaps, receiver stalls and both together.");
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
